/* hw/rtl/nsrgc_pkg.sv */
// Shared types, constants and helper functions for the NR sync raster / GSCN converter.
// No dependencies.
package nsrgc_pkg;

  localparam int unsigned VAL_W     = 27;
  localparam int unsigned N_W       = 14;
  localparam int unsigned M_W       = 3;
  localparam int unsigned Q_W       = 14;
  localparam int unsigned DIV_W     = 15;
  localparam int unsigned RCP_W     = 26;
  localparam int unsigned RCP_SHIFT = 27;
  localparam int unsigned PROD_W    = VAL_W + RCP_W;
  localparam int unsigned P_W       = Q_W + DIV_W;
  localparam int unsigned REM_W     = 15;
  localparam int unsigned X400_W    = 22;

  localparam logic [VAL_W-1:0] MID_START  = 27'd3000000;
  localparam logic [VAL_W-1:0] HIGH_START = 27'd24250000;
  localparam logic [VAL_W-1:0] HIGH_FIRST = 27'd24250080;
  localparam logic [VAL_W-1:0] GSCN_MID   = 27'd7499;
  localparam logic [VAL_W-1:0] GSCN_HIGH  = 27'd22256;

  localparam logic [DIV_W-1:0] LOW_STEP   = 15'd1200;
  localparam logic [DIV_W-1:0] LOW_OFFSET = 15'd50;
  localparam logic [DIV_W-1:0] MID_STEP   = 15'd1440;
  localparam logic [DIV_W-1:0] HIGH_STEP  = 15'd17280;
  localparam logic [DIV_W-1:0] GSCN_DIV   = 15'd3;

  localparam logic [N_W-1:0] LOW_N_MAX  = 14'd2499;
  localparam logic [N_W-1:0] MID_N_MAX  = 14'd14756;
  localparam logic [N_W-1:0] HIGH_N_MAX = 14'd4383;

  // floor(2^RCP_SHIFT / divisor): quotient estimate is exact or one low
  localparam logic [RCP_W-1:0] RCP_LOW  = RCP_W'((64'd1 << RCP_SHIFT) / 64'(LOW_STEP));
  localparam logic [RCP_W-1:0] RCP_MID  = RCP_W'((64'd1 << RCP_SHIFT) / 64'(MID_STEP));
  localparam logic [RCP_W-1:0] RCP_HIGH = RCP_W'((64'd1 << RCP_SHIFT) / 64'(HIGH_STEP));
  localparam logic [RCP_W-1:0] RCP_G3   = RCP_W'((64'd1 << RCP_SHIFT) / 64'(GSCN_DIV));

  typedef enum logic {
    CMD_TO_GSCN = 1'b0,
    CMD_TO_FREQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RNG_LOW,
    RNG_MID,
    RNG_HIGH
  } rng_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OFF   = 2'd1,
    ST_BAD_M = 2'd2,
    ST_BAD_N = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    rng_e                rng;
    status_e             err;
    logic [X400_W-1:0]   x400;
  } side_t;

  typedef struct packed {
    status_e             status;
    logic [VAL_W-1:0]    value;
    logic [M_W-1:0]      m;
    logic [N_W-1:0]      n;
  } result_t;

  function automatic logic [DIV_W-1:0] div_of(cmd_e cmd, rng_e rng);
    logic [DIV_W-1:0] d;
    case (rng)
      RNG_LOW:  d = (cmd == CMD_TO_GSCN) ? LOW_STEP : GSCN_DIV;
      RNG_MID:  d = MID_STEP;
      RNG_HIGH: d = HIGH_STEP;
      default:  d = MID_STEP;
    endcase
    return d;
  endfunction

  function automatic logic [RCP_W-1:0] rcp_of(cmd_e cmd, rng_e rng);
    logic [RCP_W-1:0] r;
    case (rng)
      RNG_LOW:  r = (cmd == CMD_TO_GSCN) ? RCP_LOW : RCP_G3;
      RNG_MID:  r = RCP_MID;
      RNG_HIGH: r = RCP_HIGH;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/nsrgc_decode.sv */
// Final decode: status priority, M/N extraction and output value per range and direction.
// Depends on nsrgc_pkg.
module nsrgc_decode (
  input  nsrgc_pkg::side_t                 side_i,
  input  logic [nsrgc_pkg::Q_W-1:0]        q_i,
  input  logic [nsrgc_pkg::REM_W-1:0]      r_i,
  input  logic [nsrgc_pkg::P_W-1:0]        p_i,
  output nsrgc_pkg::result_t               res_o
);

  function automatic logic is_mult50(logic [10:0] r);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 24; k++) begin
      if (r == 11'(k * 50)) hit = 1'b1;
    end
    return hit;
  endfunction

  logic [nsrgc_pkg::N_W+1:0]   n3;
  logic [nsrgc_pkg::N_W-1:0]   n;
  logic [nsrgc_pkg::M_W-1:0]   m;
  logic [nsrgc_pkg::VAL_W-1:0] val;
  nsrgc_pkg::status_e          st;
  logic [nsrgc_pkg::VAL_W-1:0] x400;

  assign n3   = {1'b0, q_i, 1'b0} + {2'b00, q_i};
  assign x400 = nsrgc_pkg::VAL_W'(side_i.x400);

  always_comb begin
    n   = q_i;
    m   = '0;
    val = '0;
    st  = nsrgc_pkg::ST_OK;
    if (side_i.cmd == nsrgc_pkg::CMD_TO_GSCN) begin
      case (side_i.rng)
        nsrgc_pkg::RNG_LOW: begin
          if (!is_mult50(r_i[10:0])) begin
            st = nsrgc_pkg::ST_OFF;
          end else if (r_i == nsrgc_pkg::REM_W'(nsrgc_pkg::LOW_OFFSET)) begin
            m   = 3'd1;
            val = nsrgc_pkg::VAL_W'(n3) - nsrgc_pkg::VAL_W'(1);
          end else if (r_i == nsrgc_pkg::REM_W'(3 * nsrgc_pkg::LOW_OFFSET)) begin
            m   = 3'd3;
            val = nsrgc_pkg::VAL_W'(n3);
          end else if (r_i == nsrgc_pkg::REM_W'(5 * nsrgc_pkg::LOW_OFFSET)) begin
            m   = 3'd5;
            val = nsrgc_pkg::VAL_W'(n3) + nsrgc_pkg::VAL_W'(1);
          end else begin
            st = nsrgc_pkg::ST_BAD_M;
          end
          if (st == nsrgc_pkg::ST_OK && (n == '0 || n > nsrgc_pkg::LOW_N_MAX)) begin
            st = nsrgc_pkg::ST_BAD_N;
          end
        end
        nsrgc_pkg::RNG_MID: begin
          val = nsrgc_pkg::GSCN_MID + nsrgc_pkg::VAL_W'(n);
          if (r_i != '0) st = nsrgc_pkg::ST_OFF;
          else if (n > nsrgc_pkg::MID_N_MAX) st = nsrgc_pkg::ST_BAD_N;
        end
        nsrgc_pkg::RNG_HIGH: begin
          val = nsrgc_pkg::GSCN_HIGH + nsrgc_pkg::VAL_W'(n);
          if (side_i.err != nsrgc_pkg::ST_OK) st = side_i.err;
          else if (r_i != '0) st = nsrgc_pkg::ST_OFF;
          else if (n > nsrgc_pkg::HIGH_N_MAX) st = nsrgc_pkg::ST_BAD_N;
        end
        default: st = nsrgc_pkg::ST_BAD_N;
      endcase
    end else begin
      case (side_i.rng)
        nsrgc_pkg::RNG_LOW: begin
          // freq = 400*g + offset picked by g mod 3
          case (r_i[1:0])
            2'd0: begin
              m   = 3'd3;
              val = x400 + nsrgc_pkg::VAL_W'(3 * nsrgc_pkg::LOW_OFFSET);
            end
            2'd1: begin
              m   = 3'd5;
              val = x400 - nsrgc_pkg::VAL_W'(3 * nsrgc_pkg::LOW_OFFSET);
            end
            default: begin
              m   = 3'd1;
              n   = q_i + nsrgc_pkg::Q_W'(1);
              val = x400 + nsrgc_pkg::VAL_W'(9 * nsrgc_pkg::LOW_OFFSET);
            end
          endcase
          if (n == '0 || n > nsrgc_pkg::LOW_N_MAX) st = nsrgc_pkg::ST_BAD_N;
        end
        nsrgc_pkg::RNG_MID: begin
          val = nsrgc_pkg::MID_START + p_i[nsrgc_pkg::VAL_W-1:0];
        end
        nsrgc_pkg::RNG_HIGH: begin
          val = nsrgc_pkg::HIGH_FIRST + p_i[nsrgc_pkg::VAL_W-1:0];
          st  = side_i.err;
        end
        default: st = nsrgc_pkg::ST_BAD_N;
      endcase
    end
  end

  always_comb begin
    res_o.status = st;
    if (st == nsrgc_pkg::ST_OK) begin
      res_o.value = val;
      res_o.m     = m;
      res_o.n     = n;
    end else begin
      res_o.value = '0;
      res_o.m     = '0;
      res_o.n     = '0;
    end
  end

endmodule

/* hw/rtl/nr_sync_raster_gscn_converter.sv */
// Top level: five-stage pipelined NR sync raster frequency <-> GSCN converter.
// Depends on nsrgc_pkg and nsrgc_decode.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------------------------
//  in      | in_valid_i  | in_stall_o   | cmd_i, value_in_i
//  out     | out_valid_o | out_stall_i  | status_o, value_out_o, m_index_o, n_index_o
//
// One transaction per cycle while the output is not stalled; the stages are classify, reciprocal multiply,
// back multiply, remainder correction and decode into the output register.
// Each stage holds a valid bit and loads when empty or when the next stage moves,
// so bubbles close up while the output is stalled.
// Reset clears the valid bits only.
module nr_sync_raster_gscn_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [nsrgc_pkg::VAL_W-1:0]   value_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [nsrgc_pkg::VAL_W-1:0]   value_out_o,
  output logic [nsrgc_pkg::M_W-1:0]     m_index_o,
  output logic [nsrgc_pkg::N_W-1:0]     n_index_o
);

  logic [5:1] v_q;
  logic [5:1] en;

  assign en[5]      = !v_q[5] || !out_stall_i;
  assign en[4]      = !v_q[4] || en[5];
  assign en[3]      = !v_q[3] || en[4];
  assign en[2]      = !v_q[2] || en[3];
  assign en[1]      = !v_q[1] || en[2];
  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  // stage 1: range select and offset removal
  nsrgc_pkg::side_t              side1_d, side1_q;
  logic [nsrgc_pkg::VAL_W-1:0]   d1_d, d1_q;

  always_comb begin
    side1_d.cmd  = nsrgc_pkg::cmd_e'(cmd_i);
    side1_d.err  = nsrgc_pkg::ST_OK;
    side1_d.x400 = nsrgc_pkg::X400_W'({value_in_i[12:0], 8'b0})
                 + nsrgc_pkg::X400_W'({value_in_i[12:0], 7'b0})
                 + nsrgc_pkg::X400_W'({value_in_i[12:0], 4'b0});
    if (side1_d.cmd == nsrgc_pkg::CMD_TO_GSCN) begin
      if (value_in_i < nsrgc_pkg::MID_START) begin
        side1_d.rng = nsrgc_pkg::RNG_LOW;
        d1_d        = value_in_i;
      end else if (value_in_i < nsrgc_pkg::HIGH_START) begin
        side1_d.rng = nsrgc_pkg::RNG_MID;
        d1_d        = value_in_i - nsrgc_pkg::MID_START;
      end else begin
        side1_d.rng = nsrgc_pkg::RNG_HIGH;
        d1_d        = value_in_i - nsrgc_pkg::HIGH_FIRST;
        if (value_in_i < nsrgc_pkg::HIGH_FIRST) side1_d.err = nsrgc_pkg::ST_OFF;
      end
    end else begin
      if (value_in_i < nsrgc_pkg::GSCN_MID) begin
        side1_d.rng = nsrgc_pkg::RNG_LOW;
        d1_d        = value_in_i;
      end else if (value_in_i < nsrgc_pkg::GSCN_HIGH) begin
        side1_d.rng = nsrgc_pkg::RNG_MID;
        d1_d        = value_in_i - nsrgc_pkg::GSCN_MID;
      end else begin
        side1_d.rng = nsrgc_pkg::RNG_HIGH;
        d1_d        = value_in_i - nsrgc_pkg::GSCN_HIGH;
        if (d1_d > nsrgc_pkg::VAL_W'(nsrgc_pkg::HIGH_N_MAX)) side1_d.err = nsrgc_pkg::ST_BAD_N;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side1_q <= side1_d;
      d1_q    <= d1_d;
    end
  end

  // stage 2: quotient estimate by reciprocal multiply
  nsrgc_pkg::side_t              side2_q;
  logic [nsrgc_pkg::VAL_W-1:0]   d2_q;
  logic [nsrgc_pkg::Q_W-1:0]     q2_d, q2_q;
  logic [nsrgc_pkg::PROD_W-1:0]  prod2;
  logic                          direct1;

  assign direct1 = side1_q.cmd == nsrgc_pkg::CMD_TO_FREQ && side1_q.rng != nsrgc_pkg::RNG_LOW;
  assign prod2   = nsrgc_pkg::PROD_W'(d1_q)
                 * nsrgc_pkg::PROD_W'(nsrgc_pkg::rcp_of(side1_q.cmd, side1_q.rng));
  assign q2_d    = direct1 ? d1_q[nsrgc_pkg::Q_W-1:0]
                           : prod2[nsrgc_pkg::RCP_SHIFT +: nsrgc_pkg::Q_W];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      side2_q <= side1_q;
      d2_q    <= d1_q;
      q2_q    <= q2_d;
    end
  end

  // stage 3: quotient times divisor (also N times step for GSCN to frequency)
  nsrgc_pkg::side_t              side3_q;
  logic [nsrgc_pkg::VAL_W-1:0]   d3_q;
  logic [nsrgc_pkg::Q_W-1:0]     q3_q;
  logic [nsrgc_pkg::P_W-1:0]     p3_d, p3_q;

  assign p3_d = nsrgc_pkg::P_W'(q2_q)
              * nsrgc_pkg::P_W'(nsrgc_pkg::div_of(side2_q.cmd, side2_q.rng));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      side3_q <= side2_q;
      d3_q    <= d2_q;
      q3_q    <= q2_q;
      p3_q    <= p3_d;
    end
  end

  // stage 4: remainder and one-step quotient correction
  nsrgc_pkg::side_t              side4_q;
  logic [nsrgc_pkg::Q_W-1:0]     q4_d, q4_q;
  logic [nsrgc_pkg::REM_W-1:0]   r4_d, r4_q;
  logic [nsrgc_pkg::P_W-1:0]     p4_q;
  logic [nsrgc_pkg::VAL_W-1:0]   rfull3;
  logic [nsrgc_pkg::REM_W:0]     rw3;
  logic [nsrgc_pkg::DIV_W-1:0]   div3;
  logic                          fix3;

  assign rfull3 = d3_q - p3_q[nsrgc_pkg::VAL_W-1:0];
  assign rw3    = rfull3[nsrgc_pkg::REM_W:0];
  assign div3   = nsrgc_pkg::div_of(side3_q.cmd, side3_q.rng);
  assign fix3   = !(side3_q.cmd == nsrgc_pkg::CMD_TO_FREQ && side3_q.rng != nsrgc_pkg::RNG_LOW)
                  && (rw3 >= {1'b0, div3});
  assign q4_d   = fix3 ? q3_q + nsrgc_pkg::Q_W'(1) : q3_q;
  assign r4_d   = fix3 ? nsrgc_pkg::REM_W'(rw3 - {1'b0, div3}) : rw3[nsrgc_pkg::REM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side4_q <= side3_q;
      q4_q    <= q4_d;
      r4_q    <= r4_d;
      p4_q    <= p3_q;
    end
  end

  // stage 5: decode into output register
  nsrgc_pkg::result_t res5_d, res5_q;

  nsrgc_decode u_decode (
    .side_i (side4_q),
    .q_i    (q4_q),
    .r_i    (r4_q),
    .p_i    (p4_q),
    .res_o  (res5_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[5]) res5_q <= res5_d;
  end

  assign out_valid_o = v_q[5];
  assign status_o    = res5_q.status;
  assign value_out_o = res5_q.value;
  assign m_index_o   = res5_q.m;
  assign n_index_o   = res5_q.n;

endmodule

/* hw/rtl/nsrgc_checker.sv */
// Port-level assertions for the sync raster / GSCN converter, bound to the top level.
// Depends on nsrgc_pkg and nr_sync_raster_gscn_converter.
module nsrgc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic [nsrgc_pkg::VAL_W-1:0]   value_out_o,
  input logic [nsrgc_pkg::M_W-1:0]     m_index_o,
  input logic [nsrgc_pkg::N_W-1:0]     n_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(value_out_o) && $stable(m_index_o) && $stable(n_index_o))
    else $error("stalled output transaction changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != nsrgc_pkg::ST_OK
      |-> value_out_o == '0 && m_index_o == '0 && n_index_o == '0)
    else $error("error result with nonzero fields");

  a_m_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && m_index_o != '0
      |-> m_index_o == 3'd1 || m_index_o == 3'd3 || m_index_o == 3'd5)
    else $error("illegal M on output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction did not reach output in five cycles");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

bind nr_sync_raster_gscn_converter nsrgc_checker u_nsrgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .value_out_o (value_out_o),
  .m_index_o   (m_index_o),
  .n_index_o   (n_index_o)
);

/* bench/nr_sync_raster_gscn_converter_test.sv */
// Testbench for nr_sync_raster_gscn_converter: directed table plus random raster traffic,
// with results checked against a behavioral frequency/GSCN predictor.
// Depends on nsrgc_pkg and the converter RTL.
module nr_sync_raster_gscn_converter_test;
  import nsrgc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TOP_FREQ     = 99988320;

  typedef struct {
    cmd_e             cmd;
    logic [VAL_W-1:0] value;
    bit               typed;
    result_t          res;
  } raster_case_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             cmd;
  logic [VAL_W-1:0] value_in;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       status;
  logic [VAL_W-1:0] value_out;
  logic [M_W-1:0]   m_index;
  logic [N_W-1:0]   n_index;

  result_t     expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  // typed rows: error codes and range extremes; the rest go through the predictor
  raster_case_t directed_cases[26] = '{
    '{CMD_TO_GSCN, 27'd0,         1'b1, '{ST_BAD_M, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd1,         1'b1, '{ST_OFF,   27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd50,        1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd100,       1'b1, '{ST_BAD_M, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd1250,      1'b1, '{ST_OK,    27'd2, 3'd1, 14'd1}},
    '{CMD_TO_GSCN, 27'd1350,      1'b0, '{ST_OK,    27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd2999050,   1'b1, '{ST_OK,    27'd7498, 3'd5, 14'd2499}},
    '{CMD_TO_GSCN, 27'd3000000,   1'b1, '{ST_OK,    27'd7499, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd3000001,   1'b1, '{ST_OFF,   27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd24248640,  1'b1, '{ST_OK,    27'd22255, 3'd0, 14'd14756}},
    '{CMD_TO_GSCN, 27'd24250000,  1'b1, '{ST_OFF,   27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd24250079,  1'b1, '{ST_OFF,   27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd24250080,  1'b1, '{ST_OK,    27'd22256, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd99988320,  1'b1, '{ST_OK,    27'd26639, 3'd0, 14'd4383}},
    '{CMD_TO_GSCN, 27'd100005600, 1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_GSCN, 27'd134217727, 1'b1, '{ST_OFF,   27'd0, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd0,         1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd1,         1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd2,         1'b1, '{ST_OK,    27'd1250, 3'd1, 14'd1}},
    '{CMD_TO_FREQ, 27'd3,         1'b0, '{ST_OK,    27'd0, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd7498,      1'b1, '{ST_OK,    27'd2999050, 3'd5, 14'd2499}},
    '{CMD_TO_FREQ, 27'd7499,      1'b1, '{ST_OK,    27'd3000000, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd22255,     1'b1, '{ST_OK,    27'd24248640, 3'd0, 14'd14756}},
    '{CMD_TO_FREQ, 27'd26639,     1'b1, '{ST_OK,    27'd99988320, 3'd0, 14'd4383}},
    '{CMD_TO_FREQ, 27'd26640,     1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}},
    '{CMD_TO_FREQ, 27'd134217727, 1'b1, '{ST_BAD_N, 27'd0, 3'd0, 14'd0}}
  };

  nr_sync_raster_gscn_converter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .value_out_o (value_out),
    .m_index_o   (m_index),
    .n_index_o   (n_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t predict_conversion(cmd_e conv, logic [VAL_W-1:0] raw);
    int unsigned x, rem, n, m, d, val;
    result_t r;
    r = '0;
    x = raw;
    val = 0;
    m = 0;
    n = 0;
    if (conv == CMD_TO_GSCN) begin
      if (x < MID_START) begin
        rem = x % LOW_STEP;
        n = x / LOW_STEP;
        m = rem / LOW_OFFSET;
        if (rem % LOW_OFFSET != 0) r.status = ST_OFF;
        else if (m != 1 && m != 3 && m != 5) r.status = ST_BAD_M;
        else if (n < 1 || n > LOW_N_MAX) r.status = ST_BAD_N;
        else val = 3 * n + (m - 1) / 2 - 1;
      end else if (x < HIGH_START) begin
        d = x - MID_START;
        n = d / MID_STEP;
        if (d % MID_STEP != 0) r.status = ST_OFF;
        else if (n > MID_N_MAX) r.status = ST_BAD_N;
        else val = GSCN_MID + n;
        m = 0;
      end else begin
        d = x - HIGH_FIRST;
        n = d / HIGH_STEP;
        if (x < HIGH_FIRST || d % HIGH_STEP != 0) r.status = ST_OFF;
        else if (n > HIGH_N_MAX) r.status = ST_BAD_N;
        else val = GSCN_HIGH + n;
        m = 0;
      end
    end else begin
      if (x < GSCN_MID) begin
        case (x % 3)
          1: begin m = 5; n = (x - 1) / 3; end
          2: begin m = 1; n = (x + 1) / 3; end
          default: begin m = 3; n = x / 3; end
        endcase
        if (n < 1 || n > LOW_N_MAX) r.status = ST_BAD_N;
        else val = n * LOW_STEP + m * LOW_OFFSET;
      end else if (x < GSCN_HIGH) begin
        n = x - GSCN_MID;
        if (n > MID_N_MAX) r.status = ST_BAD_N;
        else val = MID_START + n * MID_STEP;
      end else begin
        n = x - GSCN_HIGH;
        if (n > HIGH_N_MAX) r.status = ST_BAD_N;
        else val = HIGH_FIRST + n * HIGH_STEP;
      end
    end
    if (r.status == ST_OK) begin
      r.value = VAL_W'(val);
      r.m = M_W'(m);
      r.n = N_W'(n);
    end
    return r;
  endfunction

  task automatic send_conversion(input cmd_e conv, input logic [VAL_W-1:0] raw,
                                 input bit typed, input result_t typed_res);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= conv;
    value_in <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(typed ? typed_res : predict_conversion(conv, raw));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // mostly on-raster points of each range, some jitter at range edges, some raw noise
  task automatic pick_random_item(output cmd_e conv, output logic [VAL_W-1:0] raw);
    int unsigned kind, n, m, base;
    kind = $urandom_range(0, 19);
    conv = ($urandom_range(0, 1) == 0) ? CMD_TO_GSCN : CMD_TO_FREQ;
    if (conv == CMD_TO_FREQ) begin
      raw = (kind < 17) ? VAL_W'($urandom_range(0, 26700)) : VAL_W'($urandom);
    end else if (kind < 5) begin
      n = $urandom_range(0, LOW_N_MAX);
      m = (kind == 0) ? $urandom_range(0, 23) : 2 * $urandom_range(0, 2) + 1;
      raw = VAL_W'(n * LOW_STEP + m * LOW_OFFSET);
      if ($urandom_range(0, 3) == 0) raw = raw + VAL_W'($urandom_range(1, 49));
    end else if (kind < 10) begin
      n = $urandom_range(0, MID_N_MAX);
      raw = VAL_W'(MID_START + n * MID_STEP);
    end else if (kind < 14) begin
      n = $urandom_range(0, HIGH_N_MAX + 20);
      raw = VAL_W'(HIGH_FIRST + n * HIGH_STEP);
    end else if (kind < 17) begin
      case ($urandom_range(0, 2))
        0: base = MID_START;
        1: base = HIGH_START;
        default: base = TOP_FREQ;
      endcase
      raw = VAL_W'(base + $urandom_range(0, 400) - 200);
    end else begin
      raw = VAL_W'($urandom);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, status %0d value %0d", $time, status, value_out);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        end
        if (value_out !== want.value) begin
          mismatch_count++;
          $display("%0t: value_out expected %0d, got %0d", $time, want.value, value_out);
        end
        if (m_index !== want.m) begin
          mismatch_count++;
          $display("%0t: m_index expected %0d, got %0d", $time, want.m, m_index);
        end
        if (n_index !== want.n) begin
          mismatch_count++;
          $display("%0t: n_index expected %0d, got %0d", $time, want.n, n_index);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cmd_e             rand_cmd;
    logic [VAL_W-1:0] rand_value;
    rst_n = 1'b0;
    in_valid = 1'b0;
    cmd = CMD_TO_GSCN;
    value_in = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cases[i])
      send_conversion(directed_cases[i].cmd, directed_cases[i].value,
                      directed_cases[i].typed, directed_cases[i].res);
    wait_for_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 300 && i < 450) || (i >= 1200 && i < 1300);
      if (i == 900) wait_for_results();
      pick_random_item(rand_cmd, rand_value);
      send_conversion(rand_cmd, rand_value, 1'b0, '0);
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
